FILE: rtl/tte_pkg.sv
// Package for the tap tempo estimator: field widths, constants and shared types.
// It has no dependencies and is used by every other file of the block.
package tte_pkg;

    localparam int TIME_W = 40;
    localparam int THR_W  = 24;
    localparam int OUT_W  = 24;
    localparam int CNT_W  = 7;
    localparam int DVD_W  = 64;

    localparam logic [THR_W-1:0] THR_RESET = 24'd2000000;
    localparam logic [OUT_W-1:0] MAX24     = 24'hFFFFFF;
    localparam logic [DVD_W-1:0] TEMPO_NUM = 64'd15360000000;

    // One classified tap passed from the front to the back.
    typedef struct packed {
        logic [TIME_W-1:0] interval;
        logic              has_iv;
        logic              restarted;
        logic [CNT_W-1:0]  count;
    } t_job;

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [TIME_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DVD_W-1:0]  quotient;
    } t_div_rsp;

endpackage

FILE: rtl/tte_if.sv
// Channel interfaces for taps, results and the threshold register.
// Depends on tte_pkg for the field widths.
interface tte_tap_if import tte_pkg::*;;
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] tap_time_us;
    modport source (output valid, output tap_time_us, input ready);
    modport sink   (input valid, input tap_time_us, output ready);
endinterface

interface tte_res_if import tte_pkg::*;;
    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] tempo_q8;
    logic [OUT_W-1:0] std_dev_us;
    logic             tempo_valid;
    logic             tempo_saturated;
    logic             restarted;
    logic [CNT_W-1:0] tap_count;
    modport source (output valid, output tempo_q8, output std_dev_us, output tempo_valid,
                    output tempo_saturated, output restarted, output tap_count, input ready);
    modport sink   (input valid, input tempo_q8, input std_dev_us, input tempo_valid,
                    input tempo_saturated, input restarted, input tap_count, output ready);
endinterface

interface tte_cfg_if import tte_pkg::*;;
    logic             valid;
    logic             ready;
    logic [THR_W-1:0] restart_threshold_us;
    modport source (output valid, output restart_threshold_us, input ready);
    modport sink   (input valid, input restart_threshold_us, output ready);
endinterface

FILE: rtl/tte_front.sv
// Front end: takes taps, decides on restarts, tracks the tap count and forms intervals.
// Depends on tte_pkg and the channel interfaces.
module tte_front import tte_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tte_tap_if.sink i_tap,
    tte_cfg_if.sink i_cfg,
    output t_job   o_job,
    output logic   o_job_valid,
    input  logic   i_job_ready
);
    localparam int CW = $clog2(RING_DEPTH + 1);

    logic [THR_W-1:0]  r_thr;
    logic [TIME_W-1:0] r_last;
    logic [CW-1:0]     r_count, n_count;
    logic              gap_pos, restart;
    logic [TIME_W-1:0] gap;

    assign i_cfg.ready = 1'b1;
    assign i_tap.ready = i_job_ready;
    assign o_job_valid = i_tap.valid;

    always_comb begin
        gap_pos = i_tap.tap_time_us > r_last;
        gap     = gap_pos ? i_tap.tap_time_us - r_last : '0;
        restart = (r_count != '0) && gap_pos && (gap > TIME_W'(r_thr));
        if (restart) begin
            n_count = CW'(1);
        end else if (r_count < CW'(RING_DEPTH)) begin
            n_count = r_count + CW'(1);
        end else begin
            n_count = r_count;
        end
        o_job.interval  = gap;
        o_job.has_iv    = n_count >= CW'(2);
        o_job.restarted = restart;
        o_job.count     = CNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= THR_RESET;
            r_count <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_thr <= i_cfg.restart_threshold_us;
            end
            if (i_tap.valid && i_job_ready) begin
                r_count <= n_count;
            end
        end
        if (i_tap.valid && i_job_ready) begin
            r_last <= i_tap.tap_time_us;
        end
    end
endmodule

FILE: rtl/tte_queue.sv
// Two-entry queue of classified taps between the front and the back.
// Depends on tte_pkg for the item type.
module tte_queue import tte_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_job i_job,
    input  logic i_valid,
    output logic o_ready,
    output t_job o_job,
    output logic o_valid,
    input  logic i_ready
);
    t_job r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_fill;
    logic push, pop;

    assign o_ready = r_fill != 2'd2;
    assign o_valid = r_fill != 2'd0;
    assign o_job   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            if (push && !pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (pop && !push) begin
                r_fill <= r_fill - 2'd1;
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

FILE: rtl/tte_div.sv
// Restoring divider, one quotient bit per cycle, shared by the three divisions.
// Depends on tte_pkg for the request and response types.
module tte_div import tte_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int SW = $clog2(DVD_W + 1);

    logic [DVD_W-1:0]  r_num;
    logic [TIME_W-1:0] r_den;
    logic [TIME_W:0]   r_rem;
    logic [SW-1:0]     r_left;
    logic              r_busy, r_done;
    logic [TIME_W:0]   trial;

    assign trial          = {r_rem[TIME_W-1:0], r_num[DVD_W-1]};
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_left == SW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_req.start) begin
            r_num  <= i_req.dividend;
            r_den  <= i_req.divisor;
            r_rem  <= '0;
            r_left <= SW'(DVD_W);
        end else if (r_busy) begin
            r_left <= r_left - SW'(1);
            if (trial >= {1'b0, r_den}) begin
                r_rem <= trial - {1'b0, r_den};
                r_num <= {r_num[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_num <= {r_num[DVD_W-2:0], 1'b0};
            end
        end
    end
endmodule

FILE: rtl/tte_back.sv
// Back end: keeps recent intervals, sorts, trims, averages and forms tempo and deviation.
// Depends on tte_pkg, the result interface and the shared divider.
module tte_back import tte_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_job,
    input  logic      i_job_valid,
    output logic      o_job_ready,
    tte_res_if.source o_res,
    output t_div_req  o_div,
    input  t_div_rsp  i_div
);
    localparam int L  = RING_DEPTH - 1;
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int IW = $clog2(L);
    localparam int SW = TIME_W + $clog2(L + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_PREP, ST_SORT, ST_SUM, ST_MEAN, ST_TEMPO, ST_VMUL, ST_VACC,
        ST_VDIV, ST_SQRT, ST_OUT
    } t_state;

    t_state            r_state;
    logic [TIME_W-1:0] r_iv  [L];
    logic [TIME_W-1:0] r_srt [L];
    logic [TIME_W-1:0] n_srt [L];
    logic [CW-1:0]     r_n, r_trim, r_kept, r_end, r_k, r_pass;
    logic [SW-1:0]     r_sum;
    logic [TIME_W-1:0] r_mean;
    logic [DVD_W-1:0]  r_prod, r_sq, r_v, r_root, r_bit;
    logic              r_tv, r_rst, r_wait;
    logic [CNT_W-1:0]  r_cnt;
    logic [OUT_W-1:0]  r_last_tempo, r_last_sd;
    logic              r_last_sat;
    logic              r_ov, n_ov;
    logic              n_div_start;
    logic [OUT_W-1:0]  r_o_tempo, r_o_sd;
    logic              r_o_tv, r_o_sat, r_o_rst;
    logic [CNT_W-1:0]  r_o_cnt;
    t_div_req          r_div;
    logic [TIME_W-1:0] cur, diff;
    logic [31:0]       dcl;
    logic [DVD_W:0]    acc;
    logic [DVD_W-1:0]  trial;

    assign o_job_ready           = r_state == ST_IDLE;
    assign o_div                 = r_div;
    assign o_res.valid           = r_ov;
    assign o_res.tempo_q8        = r_o_tempo;
    assign o_res.std_dev_us      = r_o_sd;
    assign o_res.tempo_valid     = r_o_tv;
    assign o_res.tempo_saturated = r_o_sat;
    assign o_res.restarted       = r_o_rst;
    assign o_res.tap_count       = r_o_cnt;

    always_comb begin
        n_srt = r_srt;
        for (int j = 0; j < L - 1; j++) begin
            if (((j & 1) == int'(r_pass[0])) && (r_srt[j] > r_srt[j+1])) begin
                n_srt[j]   = r_srt[j+1];
                n_srt[j+1] = r_srt[j];
            end
        end
        cur   = r_srt[r_k[IW-1:0]];
        diff  = (cur > r_mean) ? cur - r_mean : r_mean - cur;
        dcl   = (diff[TIME_W-1:32] != '0) ? 32'hFFFFFFFF : diff[31:0];
        acc   = {1'b0, r_sq} + {1'b0, r_prod};
        trial = r_root + r_bit;
        n_div_start = (((r_state == ST_SUM) || (r_state == ST_VMUL)) && (r_k == r_end))
                      || ((r_state == ST_MEAN) && i_div.done
                          && (i_div.quotient[TIME_W-1:0] != '0));
        n_ov = (r_ov && !o_res.ready)
               || ((r_state == ST_OUT) && !r_wait && (!r_ov || o_res.ready));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_ov         <= 1'b0;
            r_last_tempo <= '0;
            r_last_sd    <= '0;
            r_last_sat   <= 1'b0;
            r_div.start  <= 1'b0;
            r_wait       <= 1'b0;
        end else begin
            r_div.start <= n_div_start;
            r_ov        <= n_ov;
            case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_tv  <= i_job.has_iv;
                        r_rst <= i_job.restarted;
                        r_cnt <= i_job.count;
                        r_n   <= CW'(i_job.count) - CW'(1);
                        if (i_job.has_iv) begin
                            r_iv[0] <= i_job.interval;
                            for (int j = 1; j < L; j++) begin
                                r_iv[j] <= r_iv[j-1];
                            end
                            r_state <= ST_PREP;
                        end else begin
                            r_state <= ST_OUT;
                        end
                    end
                end
                ST_PREP: begin
                    for (int j = 0; j < L; j++) begin
                        r_srt[j] <= (CW'(j) < r_n) ? r_iv[j] : '1;
                    end
                    if (r_n > CW'(4)) begin
                        r_trim <= (r_n - CW'(4)) >> 1;
                        r_kept <= r_n - (((r_n - CW'(4)) >> 1) << 1);
                        r_end  <= r_n - ((r_n - CW'(4)) >> 1);
                    end else begin
                        r_trim <= '0;
                        r_kept <= r_n;
                        r_end  <= r_n;
                    end
                    r_pass  <= '0;
                    r_state <= ST_SORT;
                end
                ST_SORT: begin
                    r_srt  <= n_srt;
                    r_pass <= r_pass + CW'(1);
                    if (r_pass == CW'(L - 1)) begin
                        r_k     <= r_trim;
                        r_sum   <= '0;
                        r_state <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    if (r_k == r_end) begin
                        r_div.dividend <= DVD_W'(r_sum);
                        r_div.divisor  <= TIME_W'(r_kept);
                        r_state        <= ST_MEAN;
                    end else begin
                        r_sum <= r_sum + SW'(cur);
                        r_k   <= r_k + CW'(1);
                    end
                end
                ST_MEAN: begin
                    if (i_div.done) begin
                        r_mean <= i_div.quotient[TIME_W-1:0];
                        if (i_div.quotient[TIME_W-1:0] == '0) begin
                            r_last_tempo <= MAX24;
                            r_last_sat   <= 1'b1;
                            r_k          <= r_trim;
                            r_sq         <= '0;
                            r_state      <= ST_VMUL;
                        end else begin
                            r_div.dividend <= TEMPO_NUM;
                            r_div.divisor  <= i_div.quotient[TIME_W-1:0];
                            r_state        <= ST_TEMPO;
                        end
                    end
                end
                ST_TEMPO: begin
                    if (i_div.done) begin
                        if (i_div.quotient > DVD_W'(MAX24)) begin
                            r_last_tempo <= MAX24;
                            r_last_sat   <= 1'b1;
                        end else begin
                            r_last_tempo <= i_div.quotient[OUT_W-1:0];
                            r_last_sat   <= 1'b0;
                        end
                        r_k     <= r_trim;
                        r_sq    <= '0;
                        r_state <= ST_VMUL;
                    end
                end
                ST_VMUL: begin
                    if (r_k == r_end) begin
                        r_div.dividend <= r_sq;
                        r_div.divisor  <= TIME_W'(r_kept);
                        r_state        <= ST_VDIV;
                    end else begin
                        r_prod  <= DVD_W'(dcl) * DVD_W'(dcl);
                        r_state <= ST_VACC;
                    end
                end
                ST_VACC: begin
                    r_sq    <= acc[DVD_W] ? '1 : acc[DVD_W-1:0];
                    r_k     <= r_k + CW'(1);
                    r_state <= ST_VMUL;
                end
                ST_VDIV: begin
                    if (i_div.done) begin
                        r_v     <= i_div.quotient;
                        r_root  <= '0;
                        r_bit   <= DVD_W'(1) << (DVD_W - 2);
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    if (r_v >= trial) begin
                        r_v    <= r_v - trial;
                        r_root <= (r_root >> 1) + r_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit == DVD_W'(1)) begin
                        r_wait  <= 1'b1;
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (r_wait) begin
                        r_wait    <= 1'b0;
                        r_last_sd <= (r_root > DVD_W'(MAX24)) ? MAX24 : r_root[OUT_W-1:0];
                    end else if (!r_ov || o_res.ready) begin
                        r_o_tempo <= r_last_tempo;
                        r_o_sd    <= r_last_sd;
                        r_o_tv    <= r_tv;
                        r_o_sat   <= r_last_sat;
                        r_o_rst   <= r_rst;
                        r_o_cnt   <= r_cnt;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule

FILE: rtl/tap_tempo_estimator.sv
// Top level of the tap tempo estimator: front end, item queue, back end and divider.
// Depends on tte_pkg, the channel interfaces and the tte_* modules.
// Each tap item yields one result item. A tap is taken as soon as the two-entry queue has
// room, so taps are accepted while an earlier one is still being evaluated. Evaluating one
// tap with two or more held taps takes RING_DEPTH-1 sort passes whatever the count, a
// summing step and a squaring step per kept interval (at most five are kept), up to three
// divisions in the shared divider and 32 root steps; a tap with fewer than two held taps
// goes straight to the result.
module tap_tempo_estimator import tte_pkg::*; #(
    parameter int RING_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tte_tap_if.sink    i_tap,
    tte_cfg_if.sink    i_cfg,
    tte_res_if.source  o_res
);
    t_job     front_job, back_job;
    logic     front_valid, front_ready, back_valid, back_ready;
    t_div_req div_req;
    t_div_rsp div_rsp;

    tte_front #(.RING_DEPTH(RING_DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tap       (i_tap),
        .i_cfg       (i_cfg),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    tte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (front_job),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .o_job   (back_job),
        .o_valid (back_valid),
        .i_ready (back_ready)
    );

    tte_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (back_job),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .o_res       (o_res),
        .o_div       (div_req),
        .i_div       (div_rsp)
    );

    tte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );
endmodule

FILE: test/tb.sv
// Self-checking testbench for tap_tempo_estimator: directed and random taps, threshold changes.
// Depends on tte_pkg, the channel interfaces in rtl/tte_if.sv and the tap_tempo_estimator top.
module tb;
    import tte_pkg::*;

    localparam int DEPTH = 16;
    localparam longint LIMIT = 3000000;

    typedef struct packed {
        logic [OUT_W-1:0] tempo_q8;
        logic [OUT_W-1:0] std_dev_us;
        logic             tempo_valid;
        logic             tempo_saturated;
        logic             restarted;
        logic [CNT_W-1:0] tap_count;
    } t_tempo;

    logic i_clk = 0;
    logic i_rst_n = 0;

    tte_tap_if tap();
    tte_cfg_if cfg();
    tte_res_if res();

    tap_tempo_estimator #(.RING_DEPTH(DEPTH)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_tap(tap.sink), .i_cfg(cfg.sink), .o_res(res.source)
    );

    always #5 i_clk = ~i_clk;

    logic [TIME_W-1:0] ring [DEPTH];
    int unsigned       wr_slot;
    int unsigned       held;
    logic [OUT_W-1:0]  prev_tempo;
    logic [OUT_W-1:0]  prev_sd;
    logic              prev_sat;
    logic [THR_W-1:0]  threshold;
    logic [TIME_W-1:0] clock_us;

    t_tempo expected_tempos[$];
    int     mismatches;
    int     results_seen;
    longint cycles;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_tempo predict_tempo(logic [TIME_W-1:0] t);
        t_tempo          e;
        longint unsigned iv [DEPTH];
        longint unsigned v, sum, mean, sq, d, p, tq;
        int unsigned     n, trim, kept, cur, pv;
        int              j;
        e = '0;
        if (held > 0 && t > ring[wr_slot] && t - ring[wr_slot] > threshold) begin
            held = 0;
            e.restarted = 1;
        end
        wr_slot = (wr_slot + 1) % DEPTH;
        ring[wr_slot] = t;
        if (held < DEPTH) held++;
        if (held >= 2) begin
            n = held - 1;
            for (int k = 0; k < n; k++) begin
                cur = (wr_slot + DEPTH - k) % DEPTH;
                pv = (cur + DEPTH - 1) % DEPTH;
                iv[k] = (ring[cur] >= ring[pv]) ? ring[cur] - ring[pv] : 0;
            end
            for (int k = 1; k < n; k++) begin
                v = iv[k];
                j = k;
                while (j > 0 && iv[j-1] > v) begin
                    iv[j] = iv[j-1];
                    j--;
                end
                iv[j] = v;
            end
            trim = (n > 4) ? (n - 4) / 2 : 0;
            kept = n - 2 * trim;
            sum = 0;
            for (int k = trim; k < n - trim; k++) sum += iv[k];
            mean = sum / kept;
            if (mean == 0) begin
                tq = MAX24;
                prev_sat = 1;
            end else begin
                tq = TEMPO_NUM / mean;
                prev_sat = 0;
                if (tq > MAX24) begin
                    tq = MAX24;
                    prev_sat = 1;
                end
            end
            sq = 0;
            for (int k = trim; k < n - trim; k++) begin
                d = (iv[k] > mean) ? iv[k] - mean : mean - iv[k];
                if (d > 64'hFFFFFFFF) d = 64'hFFFFFFFF;
                p = d * d;
                sq = (sq > ~p) ? ~64'd0 : sq + p;
            end
            v = root_floor(sq / kept);
            if (v > MAX24) v = MAX24;
            prev_tempo = tq[OUT_W-1:0];
            prev_sd = v[OUT_W-1:0];
        end
        e.tempo_q8 = prev_tempo;
        e.std_dev_us = prev_sd;
        e.tempo_valid = held >= 2;
        e.tempo_saturated = prev_sat;
        e.tap_count = held[CNT_W-1:0];
        return e;
    endfunction

    function automatic int gap_length();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0) n = 0;
        return n;
    endfunction

    task automatic send_tap(logic [TIME_W-1:0] t);
        int n;
        tap.valid <= 1;
        tap.tap_time_us <= t;
        @(posedge i_clk);
        while (!tap.ready) @(posedge i_clk);
        expected_tempos.insert(expected_tempos.size(), predict_tempo(t));
        clock_us = t;
        n = gap_length();
        if (n != 0) begin
            tap.valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        tap.valid <= 0;
        while (expected_tempos.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] v);
        drain();
        cfg.valid <= 1;
        cfg.restart_threshold_us <= v;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 0;
        threshold = v;
        @(posedge i_clk);
    endtask

    // Steps a timestamp forward, occasionally backwards, with a mostly steady beat.
    task automatic send_beat(int taps, int beat, int jitter);
        logic [TIME_W-1:0] t;
        longint            s;
        for (int k = 0; k < taps; k++) begin
            s = beat + $signed($urandom_range(0, 2 * jitter)) - jitter;
            if ($urandom_range(0, 30) == 0) s = -longint'($urandom_range(0, 5000));
            if (s < 0 && clock_us < -s) s = 0;
            t = clock_us + s;
            send_tap(t);
        end
    endtask

    task automatic test_directed();
        send_tap(40'd0);
        send_tap(40'd0);
        send_tap(40'd500);
        send_tap(40'd1000);
        send_tap(40'd1916);
        send_tap(40'd1900);
        send_tap(40'd2000000 + 40'd1900);
        send_tap(40'd4000000 + 40'd1901);
        for (int k = 0; k < 18; k++) send_tap(clock_us + 40'd400000 + k * 3000);
        send_tap(40'hFF_FFFF_FFF0);
        send_tap(40'hFF_FFFF_FFFF);
        send_tap(40'hFF_FFFF_FFFF);
        send_tap(40'd5);
    endtask

    task automatic test_threshold_extremes();
        write_threshold(24'd1);
        send_tap(clock_us + 1);
        send_tap(clock_us + 2);
        send_tap(clock_us + 1);
        send_tap(clock_us);
        write_threshold(24'hFFFFFF);
        send_tap(clock_us + 40'hFFFFFF);
        send_tap(clock_us + 40'hFFFFFF + 1);
        send_beat(20, 16000000, 700000);
        write_threshold(24'd0);
        send_tap(clock_us);
        send_tap(clock_us + 1);
    endtask

    task automatic test_random();
        logic [THR_W-1:0] thr;
        for (int phase = 0; phase < 8; phase++) begin
            thr = (phase % 2) ? $urandom_range(1, 24'hFFFFFF) : THR_RESET;
            write_threshold(thr);
            for (int k = 0; k < 10; k++) begin
                case ($urandom_range(0, 5))
                    0: send_beat($urandom_range(2, 30), $urandom_range(0, 1500), 300);
                    1: send_tap({$urandom, $urandom} & 40'hFF_FFFF_FFFF);
                    2: send_tap(clock_us + $urandom_range(0, 2 * thr));
                    default: send_beat($urandom_range(3, 40), $urandom_range(250000, 1500000),
                                       $urandom_range(0, 60000));
                endcase
            end
        end
        while (results_seen < 1630) send_beat(20, $urandom_range(300000, 900000), 20000);
    endtask

    // Result side: random stalls and comparison of every field against the expected item.
    always @(posedge i_clk) begin
        t_tempo e;
        t_tempo a;
        if (!i_rst_n) begin
            res.ready <= 0;
        end else begin
            if (res.valid && res.ready) begin
                a = '{res.tempo_q8, res.std_dev_us, res.tempo_valid, res.tempo_saturated,
                      res.restarted, res.tap_count};
                results_seen++;
                if (expected_tempos.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result item %p", a);
                end else begin
                    e = expected_tempos.pop_front();
                    if (a !== e) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch: expected %p got %p", e, a);
                    end
                end
            end
            res.ready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 30) == 0);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tap_tempo_estimator regression: fail");
            $finish;
        end
    end

    initial begin
        tap.valid = 0;
        tap.tap_time_us = '0;
        cfg.valid = 0;
        cfg.restart_threshold_us = '0;
        res.ready = 0;
        mismatches = 0;
        results_seen = 0;
        cycles = 0;
        wr_slot = 0;
        held = 0;
        prev_tempo = 0;
        prev_sd = 0;
        prev_sat = 0;
        threshold = THR_RESET;
        clock_us = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        test_directed();
        test_threshold_extremes();
        test_random();
        drain();
        $display("Covered %0d result items over several restart thresholds,", results_seen);
        $display("including restarts, backward steps, saturation and full rings.");
        if (mismatches == 0 && expected_tempos.size() == 0) begin
            $display("tap_tempo_estimator regression: pass");
        end else begin
            $display("%0d mismatches, %0d left over", mismatches, expected_tempos.size());
            $display("tap_tempo_estimator regression: fail");
        end
        $finish;
    end
endmodule
